// File: design/gha_pkg.sv
package gha_pkg;

    localparam int DEF_NUM_SLOTS = 64;
    localparam int DEF_GEN_BITS  = 16;
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE   = 2'd0,
        ACT_DESTROY  = 2'd1,
        ACT_CONTAINS = 2'd2,
        ACT_CLEAR    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_STALE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_HOLD
    } ctrl_state_t;

endpackage

// File: design/generational_handle_allocator.sv
// Create, destroy and contains read the slot after the accepting edge and load the result
// register from that read; create first steps over each alive slot at the lowest-free hint.
// Clear makes one slot-memory read-modify-write per slot, then loads the result register.
// One item in flight: a new item is taken only after the result of the last has gone to the
// result register; a result that cannot drain holds s_ready low until it can.
// Reset: synchronous, active low; afterward a clearing pass writes every slot free at
// generation one while s_ready stays low.
module generational_handle_allocator #(
    parameter int   NUM_SLOTS = gha_pkg::DEF_NUM_SLOTS,
    parameter int   GEN_BITS  = gha_pkg::DEF_GEN_BITS,
    localparam int  IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int  CNT_W     = $clog2(NUM_SLOTS + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gha_pkg::ACTION_W-1:0] s_action,
    input  logic [IDX_W-1:0]             s_handle_index,
    input  logic [GEN_BITS-1:0]          s_handle_generation,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gha_pkg::STATUS_W-1:0] m_status,
    output logic                         m_found,
    output logic [IDX_W-1:0]             m_new_index,
    output logic [GEN_BITS-1:0]          m_new_generation,
    output logic [CNT_W-1:0]             m_live_count
);

    logic                 out_free;
    logic                 res_valid;
    gha_pkg::status_t     res_status;
    logic                 res_found;
    logic [IDX_W-1:0]     res_new_index;
    logic [GEN_BITS-1:0]  res_new_generation;
    logic [CNT_W-1:0]     res_live_count;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [GEN_BITS:0]    ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [GEN_BITS:0]    ram_rdata;

    logic                          m_valid_reg;
    logic [gha_pkg::STATUS_W-1:0]  m_status_reg;
    logic                          m_found_reg;
    logic [IDX_W-1:0]              m_index_reg;
    logic [GEN_BITS-1:0]           m_gen_reg;
    logic [CNT_W-1:0]              m_count_reg;

    gha_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .GEN_BITS  (GEN_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_handle_index      (s_handle_index),
        .s_handle_generation (s_handle_generation),
        .out_free            (out_free),
        .res_valid           (res_valid),
        .res_status          (res_status),
        .res_found           (res_found),
        .res_new_index       (res_new_index),
        .res_new_generation  (res_new_generation),
        .res_live_count      (res_live_count),
        .ram_we              (ram_we),
        .ram_waddr           (ram_waddr),
        .ram_wdata           (ram_wdata),
        .ram_raddr           (ram_raddr),
        .ram_rdata           (ram_rdata)
    );

    gha_ram #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (GEN_BITS + 1)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The result register takes a new item when it is empty or being drained.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            m_status_reg <= res_status;
            m_found_reg  <= res_found;
            m_index_reg  <= res_new_index;
            m_gen_reg    <= res_new_generation;
            m_count_reg  <= res_live_count;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found          = m_found_reg;
    assign m_new_index      = m_index_reg;
    assign m_new_generation = m_gen_reg;
    assign m_live_count     = m_count_reg;

endmodule

// File: design/gha_ram.sv
module gha_ram #(
    parameter int DEPTH  = gha_pkg::DEF_NUM_SLOTS,
    parameter int ADDR_W = 6,
    parameter int DATA_W = gha_pkg::DEF_GEN_BITS + 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/gha_ctrl.sv
module gha_ctrl #(
    parameter int NUM_SLOTS = gha_pkg::DEF_NUM_SLOTS,
    parameter int GEN_BITS  = gha_pkg::DEF_GEN_BITS,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gha_pkg::ACTION_W-1:0] s_action,
    input  logic [IDX_W-1:0]             s_handle_index,
    input  logic [GEN_BITS-1:0]          s_handle_generation,
    input  logic                         out_free,
    output logic                         res_valid,
    output gha_pkg::status_t             res_status,
    output logic                         res_found,
    output logic [IDX_W-1:0]             res_new_index,
    output logic [GEN_BITS-1:0]          res_new_generation,
    output logic [CNT_W-1:0]             res_live_count,
    output logic                         ram_we,
    output logic [IDX_W-1:0]             ram_waddr,
    output logic [GEN_BITS:0]            ram_wdata,
    output logic [IDX_W-1:0]             ram_raddr,
    input  logic [GEN_BITS:0]            ram_rdata
);

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(NUM_SLOTS);
    localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W + 1)'(NUM_SLOTS);

    gha_pkg::ctrl_state_t state_reg, state_next;
    gha_pkg::action_t     act_reg, act_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 idx_ok_reg, idx_ok_next;
    logic [GEN_BITS-1:0]  gen_reg, gen_next;
    logic [CNT_W-1:0]     hint_reg, hint_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;

    gha_pkg::status_t     res_status_reg, res_status_next;
    logic                 res_found_reg, res_found_next;
    logic [IDX_W-1:0]     res_index_reg, res_index_next;
    logic [GEN_BITS-1:0]  res_gen_reg, res_gen_next;
    logic [CNT_W-1:0]     res_count_reg, res_count_next;

    logic                 fin;
    gha_pkg::status_t     fin_status;
    logic                 fin_found;
    logic [IDX_W-1:0]     fin_index;
    logic [GEN_BITS-1:0]  fin_gen;
    logic [CNT_W-1:0]     fin_count;

    logic                 rd_alive;
    logic [GEN_BITS-1:0]  rd_gen;
    logic [GEN_BITS-1:0]  gen_inc;
    logic [GEN_BITS-1:0]  gen_bump;
    logic [CNT_W-1:0]     hint_inc;
    logic                 handle_live;
    logic                 in_idx_ok;

    assign rd_alive    = ram_rdata[GEN_BITS];
    assign rd_gen      = ram_rdata[GEN_BITS-1:0];
    assign gen_inc     = rd_gen + GEN_BITS'(1);
    // A generation of zero marks an invalid handle, so the wrap lands on one.
    assign gen_bump    = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
    assign hint_inc    = hint_reg + CNT_W'(1);
    assign handle_live = (gen_reg != '0) && idx_ok_reg && rd_alive && (rd_gen == gen_reg);
    assign in_idx_ok   = ({1'b0, s_handle_index} < SLOTS_EXT);
    assign s_ready     = (state_reg == gha_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gha_pkg::ST_INIT;
            hint_reg  <= '0;
            total_reg <= '0;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            hint_reg  <= hint_next;
            total_reg <= total_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        idx_reg        <= idx_next;
        idx_ok_reg     <= idx_ok_next;
        gen_reg        <= gen_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_index_reg  <= res_index_next;
        res_gen_reg    <= res_gen_next;
        res_count_reg  <= res_count_next;
    end

    always_comb begin
        state_next      = state_reg;
        act_next        = act_reg;
        idx_next        = idx_reg;
        idx_ok_next     = idx_ok_reg;
        gen_next        = gen_reg;
        hint_next       = hint_reg;
        total_next      = total_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_index_next  = res_index_reg;
        res_gen_next    = res_gen_reg;
        res_count_next  = res_count_reg;

        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = {1'b0, GEN_BITS'(1)};
        ram_raddr = ptr_reg;

        fin        = 1'b0;
        fin_status = gha_pkg::STATUS_OK;
        fin_found  = 1'b0;
        fin_index  = '0;
        fin_gen    = '0;
        fin_count  = total_reg;

        res_valid          = 1'b0;
        res_status         = res_status_reg;
        res_found          = res_found_reg;
        res_new_index      = res_index_reg;
        res_new_generation = res_gen_reg;
        res_live_count     = res_count_reg;

        unique case (state_reg)
            gha_pkg::ST_INIT: begin
                // Every slot starts free at generation one.
                ram_we   = 1'b1;
                ptr_next = ptr_reg + IDX_W'(1);
                if (ptr_reg == LAST_IDX) begin
                    ptr_next   = '0;
                    state_next = gha_pkg::ST_IDLE;
                end
            end
            gha_pkg::ST_IDLE: begin
                if (s_valid) begin
                    act_next    = gha_pkg::action_t'(s_action);
                    idx_next    = s_handle_index;
                    idx_ok_next = in_idx_ok;
                    gen_next    = s_handle_generation;
                    state_next  = gha_pkg::ST_EXEC;
                    unique case (gha_pkg::action_t'(s_action))
                        gha_pkg::ACT_CREATE: begin
                            ram_raddr = (total_reg == FULL_CNT) ? '0 : hint_reg[IDX_W-1:0];
                        end
                        gha_pkg::ACT_DESTROY, gha_pkg::ACT_CONTAINS: begin
                            ram_raddr = in_idx_ok ? s_handle_index : '0;
                        end
                        gha_pkg::ACT_CLEAR: begin
                            ram_raddr  = '0;
                            ptr_next   = '0;
                            state_next = gha_pkg::ST_CLEAR;
                        end
                        default: begin
                            state_next = gha_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            gha_pkg::ST_EXEC: begin
                unique case (act_reg)
                    gha_pkg::ACT_CREATE: begin
                        if (total_reg == FULL_CNT) begin
                            fin        = 1'b1;
                            fin_status = gha_pkg::STATUS_FULL;
                        end else if (rd_alive) begin
                            // Every slot below the hint is alive, so step forward.
                            hint_next = hint_inc;
                            ram_raddr = hint_inc[IDX_W-1:0];
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = hint_reg[IDX_W-1:0];
                            ram_wdata  = {1'b1, rd_gen};
                            total_next = total_reg + CNT_W'(1);
                            hint_next  = hint_inc;
                            fin        = 1'b1;
                            fin_index  = hint_reg[IDX_W-1:0];
                            fin_gen    = rd_gen;
                            fin_count  = total_reg + CNT_W'(1);
                        end
                    end
                    gha_pkg::ACT_DESTROY: begin
                        fin = 1'b1;
                        if (handle_live) begin
                            ram_we     = 1'b1;
                            ram_waddr  = idx_reg;
                            ram_wdata  = {1'b0, gen_bump};
                            total_next = total_reg - CNT_W'(1);
                            fin_count  = total_reg - CNT_W'(1);
                            if (CNT_W'(idx_reg) < hint_reg) begin
                                hint_next = CNT_W'(idx_reg);
                            end
                        end else begin
                            fin_status = gha_pkg::STATUS_STALE;
                        end
                    end
                    gha_pkg::ACT_CONTAINS: begin
                        fin       = 1'b1;
                        fin_found = handle_live;
                    end
                    default: begin
                        state_next = gha_pkg::ST_IDLE;
                    end
                endcase
            end
            gha_pkg::ST_CLEAR: begin
                // Data for slot ptr arrives now while the next slot is read.
                if (rd_alive) begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_reg;
                    ram_wdata = {1'b0, gen_bump};
                end
                ram_raddr = ptr_reg + IDX_W'(1);
                ptr_next  = ptr_reg + IDX_W'(1);
                if (ptr_reg == LAST_IDX) begin
                    ram_raddr  = '0;
                    ptr_next   = '0;
                    total_next = '0;
                    hint_next  = '0;
                    fin        = 1'b1;
                    fin_count  = '0;
                end
            end
            gha_pkg::ST_HOLD: begin
                res_valid = 1'b1;
                if (out_free) begin
                    state_next = gha_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gha_pkg::ST_IDLE;
            end
        endcase

        if (fin) begin
            res_valid          = 1'b1;
            res_status         = fin_status;
            res_found          = fin_found;
            res_new_index      = fin_index;
            res_new_generation = fin_gen;
            res_live_count     = fin_count;
            if (out_free) begin
                state_next = gha_pkg::ST_IDLE;
            end else begin
                state_next      = gha_pkg::ST_HOLD;
                res_status_next = fin_status;
                res_found_next  = fin_found;
                res_index_next  = fin_index;
                res_gen_next    = fin_gen;
                res_count_next  = fin_count;
            end
        end
    end

endmodule

// File: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gha_pkg::*;

    localparam int NUM_SLOTS      = DEF_NUM_SLOTS;
    localparam int GEN_BITS       = DEF_GEN_BITS;
    localparam int IDX_W          = $clog2(NUM_SLOTS);
    localparam int CNT_W          = $clog2(NUM_SLOTS + 1);
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 760;
    localparam int QUIET_FROM     = 660;
    localparam int HOLD_CYCLES    = 200;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT_CYCLES = 5_000_000;

    typedef struct packed {
        action_t              action;
        logic [IDX_W-1:0]     idx;
        logic [GEN_BITS-1:0]  gen;
    } alloc_req_t;

    typedef struct packed {
        status_t              status;
        logic                 found;
        logic [IDX_W-1:0]     new_index;
        logic [GEN_BITS-1:0]  new_generation;
        logic [CNT_W-1:0]     live_count;
    } alloc_result_t;

    typedef struct packed {
        action_t              action;
        logic [IDX_W-1:0]     idx;
        logic [GEN_BITS-1:0]  gen;
        logic                 typed;
        alloc_result_t        want;
    } dir_row_t;

    localparam alloc_result_t NO_RESULT = '0;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ACTION_W-1:0]   s_action = '0;
    logic [IDX_W-1:0]      s_handle_index = '0;
    logic [GEN_BITS-1:0]   s_handle_generation = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic                  m_found;
    logic [IDX_W-1:0]      m_new_index;
    logic [GEN_BITS-1:0]   m_new_generation;
    logic [CNT_W-1:0]      m_live_count;

    // Shadow copy of the slot store, advanced as each item is accepted.
    bit                    slot_live [NUM_SLOTS];
    logic [GEN_BITS-1:0]   slot_gen [NUM_SLOTS];
    logic [CNT_W-1:0]      live_total;

    alloc_result_t         pending_results[$];
    int                    mismatch_count = 0;
    bit                    tx_stalls = 1'b1;
    logic                  rx_stalls = 1'b1;
    logic                  hold_off_req = 1'b0;

    // Slot contents after reset are free at generation one.
    dir_row_t directed_rows [23] = '{
        '{ACT_CONTAINS, 6'd0,  16'd1,     1'b1, '{STATUS_OK,    1'b0, 6'd0, 16'd0, 7'd0}},
        '{ACT_DESTROY,  6'd0,  16'd1,     1'b1, '{STATUS_STALE, 1'b0, 6'd0, 16'd0, 7'd0}},
        '{ACT_CREATE,   6'd63, 16'hFFFF,  1'b0, NO_RESULT},
        '{ACT_CREATE,   6'd0,  16'd0,     1'b0, NO_RESULT},
        '{ACT_CONTAINS, 6'd0,  16'd1,     1'b0, NO_RESULT},
        '{ACT_CONTAINS, 6'd0,  16'd0,     1'b1, '{STATUS_OK,    1'b0, 6'd0, 16'd0, 7'd2}},
        '{ACT_CONTAINS, 6'd0,  16'hFFFF,  1'b1, '{STATUS_OK,    1'b0, 6'd0, 16'd0, 7'd2}},
        '{ACT_DESTROY,  6'd0,  16'd0,     1'b1, '{STATUS_STALE, 1'b0, 6'd0, 16'd0, 7'd2}},
        '{ACT_DESTROY,  6'd0,  16'd1,     1'b0, NO_RESULT},
        '{ACT_DESTROY,  6'd0,  16'd1,     1'b1, '{STATUS_STALE, 1'b0, 6'd0, 16'd0, 7'd1}},
        '{ACT_CONTAINS, 6'd0,  16'd2,     1'b0, NO_RESULT},
        '{ACT_CREATE,   6'd0,  16'd0,     1'b0, NO_RESULT},
        '{ACT_CONTAINS, 6'd63, 16'd1,     1'b1, '{STATUS_OK,    1'b0, 6'd0, 16'd0, 7'd2}},
        '{ACT_DESTROY,  6'd63, 16'hFFFF,  1'b1, '{STATUS_STALE, 1'b0, 6'd0, 16'd0, 7'd2}},
        '{ACT_CLEAR,    6'd0,  16'd0,     1'b1, '{STATUS_OK,    1'b0, 6'd0, 16'd0, 7'd0}},
        '{ACT_CONTAINS, 6'd1,  16'd1,     1'b0, NO_RESULT},
        '{ACT_CREATE,   6'd0,  16'd0,     1'b0, NO_RESULT},
        '{ACT_CREATE,   6'd0,  16'd0,     1'b0, NO_RESULT},
        '{ACT_CONTAINS, 6'd1,  16'd2,     1'b0, NO_RESULT},
        '{ACT_CLEAR,    6'd63, 16'hFFFF,  1'b1, '{STATUS_OK,    1'b0, 6'd0, 16'd0, 7'd0}},
        '{ACT_CLEAR,    6'd0,  16'd0,     1'b1, '{STATUS_OK,    1'b0, 6'd0, 16'd0, 7'd0}},
        '{ACT_CONTAINS, 6'd63, 16'hFFFF,  1'b0, NO_RESULT},
        '{ACT_CREATE,   6'd21, 16'h5A5A,  1'b0, NO_RESULT}
    };

    generational_handle_allocator #(
        .NUM_SLOTS(NUM_SLOTS),
        .GEN_BITS(GEN_BITS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_handle_index(s_handle_index),
        .s_handle_generation(s_handle_generation),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_found(m_found),
        .m_new_index(m_new_index),
        .m_new_generation(m_new_generation),
        .m_live_count(m_live_count)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [GEN_BITS-1:0] bump_gen(logic [GEN_BITS-1:0] g);
        // Generation zero marks an invalid handle, so the wrap lands on one.
        return (g == '1) ? GEN_BITS'(1) : g + 1'b1;
    endfunction

    function automatic bit handle_is_live(logic [IDX_W-1:0] idx, logic [GEN_BITS-1:0] gen);
        return (gen != '0) && slot_live[idx] && (slot_gen[idx] == gen);
    endfunction

    function automatic alloc_result_t apply_action(alloc_req_t req);
        alloc_result_t res;
        bit placed;
        res = NO_RESULT;
        placed = 1'b0;
        case (req.action)
            ACT_CREATE: begin
                for (int i = 0; i < NUM_SLOTS && !placed; i++) begin
                    if (!slot_live[i]) begin
                        slot_live[i] = 1'b1;
                        live_total = live_total + 1'b1;
                        res.new_index = IDX_W'(i);
                        res.new_generation = slot_gen[i];
                        placed = 1'b1;
                    end
                end
                if (!placed) begin
                    res.status = STATUS_FULL;
                end
            end
            ACT_DESTROY: begin
                if (handle_is_live(req.idx, req.gen)) begin
                    slot_live[req.idx] = 1'b0;
                    slot_gen[req.idx] = bump_gen(slot_gen[req.idx]);
                    live_total = live_total - 1'b1;
                end else begin
                    res.status = STATUS_STALE;
                end
            end
            ACT_CONTAINS: begin
                res.found = handle_is_live(req.idx, req.gen);
            end
            default: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_live[i]) begin
                        slot_live[i] = 1'b0;
                        slot_gen[i] = bump_gen(slot_gen[i]);
                    end
                end
                live_total = '0;
            end
        endcase
        res.live_count = live_total;
        return res;
    endfunction

    // Mostly handles that are live or one generation old, with some noise on top.
    function automatic alloc_req_t draw_request();
        alloc_req_t req;
        int live_slots[$];
        int pick;
        int r;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_live[i]) begin
                live_slots.insert(live_slots.size(), i);
            end
        end
        r = $urandom_range(0, 99);
        req.action = ACT_CREATE;
        req.idx = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
        req.gen = GEN_BITS'($urandom);
        if (r >= 35 && r < 70) begin
            req.action = (r < 55) ? ACT_DESTROY : ACT_CONTAINS;
            if (live_slots.size() > 0) begin
                pick = live_slots[$urandom_range(0, live_slots.size() - 1)];
                req.idx = IDX_W'(pick);
                req.gen = slot_gen[pick];
            end
        end else if (r >= 70 && r < 80) begin
            req.action = (r < 76) ? ACT_DESTROY : ACT_CONTAINS;
            req.gen = slot_gen[req.idx] - GEN_BITS'($urandom_range(0, 1));
        end else if (r >= 80 && r < 95) begin
            req.action = action_t'($urandom_range(1, 2));
            if (r >= 92) begin
                req.gen = '0;
            end
        end else if (r >= 95 && r < 98) begin
            req.action = ACT_CLEAR;
        end else if (r >= 98) begin
            req.action = action_t'($urandom_range(0, 3));
        end
        return req;
    endfunction

    // Holds the item on the port until it is taken, then records what it should produce.
    task automatic issue_request(alloc_req_t req, bit typed, alloc_result_t typed_want);
        alloc_result_t predicted;
        s_valid <= 1'b1;
        s_action <= req.action;
        s_handle_index <= req.idx;
        s_handle_generation <= req.gen;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_action(req);
        pending_results.insert(pending_results.size(), typed ? typed_want : predicted);
    endtask

    task automatic sender_gap();
        if (tx_stalls && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic fill_store();
        alloc_req_t req;
        req.action = ACT_CREATE;
        while (live_total != CNT_W'(NUM_SLOTS)) begin
            req.idx = IDX_W'($urandom);
            req.gen = GEN_BITS'($urandom);
            issue_request(req, 1'b0, NO_RESULT);
            sender_gap();
        end
        // A few more creates against the full store.
        repeat (3) begin
            req.idx = IDX_W'($urandom);
            req.gen = GEN_BITS'($urandom);
            issue_request(req, 1'b0, NO_RESULT);
            sender_gap();
        end
    endtask

    initial begin : rx_side
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        alloc_result_t want;
        alloc_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{status_t'(m_status), m_found, m_new_index, m_new_generation,
                    m_live_count};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: result with no item pending: status=%0d found=%0d",
                             $realtime, got.status, got.found);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch status %0d/%0d found %0d/%0d index %0d/%0d",
                                 $realtime, want.status, got.status, want.found, got.found,
                                 want.new_index, got.new_index);
                        $display("    generation %0d/%0d live_count %0d/%0d (expected/actual)",
                                 want.new_generation, got.new_generation,
                                 want.live_count, got.live_count);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        alloc_req_t req;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_gen[i] = GEN_BITS'(1);
        end
        live_total = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            req = '{directed_rows[i].action, directed_rows[i].idx, directed_rows[i].gen};
            issue_request(req, directed_rows[i].typed, directed_rows[i].want);
            sender_gap();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n < QUIET_FROM && n % 150 == 0) begin
                tx_stalls = ($urandom_range(0, 3) != 0);
                rx_stalls <= ($urandom_range(0, 3) != 0);
            end
            if (n == QUIET_FROM) begin
                tx_stalls = 1'b0;
                rx_stalls <= 1'b0;
            end
            if (n == 150 || n == 550) begin
                fill_store();
            end
            if (n == 350) begin
                hold_off_req <= 1'b1;
            end
            if (n == 450) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
            end
            issue_request(draw_request(), 1'b0, NO_RESULT);
            sender_gap();
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (NUM_SLOTS + 8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_top failed");
        $finish;
    end

endmodule
